FILE: src/twq_pkg.sv
package twq_pkg;

    localparam int MAX_THREADS = 32;
    localparam int MAX_RESULTS = 32;
    localparam int THR_W       = $clog2(MAX_THREADS);
    localparam int CNT_W       = $clog2(MAX_THREADS + 1);
    localparam int RES_W       = $clog2(MAX_RESULTS + 1);
    localparam int TID_W       = 5;
    localparam int TIME_W      = 64;
    localparam int PER_W       = 32;
    localparam int STAT_W      = 3;

    localparam logic       CMD_BLOCK  = 1'b0;
    localparam logic       CMD_EXPIRE = 1'b1;

    localparam logic [STAT_W-1:0] ST_QUEUED  = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd1;
    localparam logic [STAT_W-1:0] ST_WAITING = 3'd2;
    localparam logic [STAT_W-1:0] ST_WOKEN   = 3'd3;
    localparam logic [STAT_W-1:0] ST_NONE    = 3'd4;

    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] wtime;
        logic [TID_W-1:0]  tid;
    } t_entry;

    typedef struct packed {
        logic insert;
        logic pop;
    } t_cell_ctl;

endpackage

FILE: src/twq_cell.sv
module twq_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  twq_pkg::t_cell_ctl i_ctl,
    input  twq_pkg::t_entry    i_key,
    input  twq_pkg::t_entry    i_prev,
    input  logic               i_prev_lt,
    input  twq_pkg::t_entry    i_next,
    output twq_pkg::t_entry    o_entry,
    output logic               o_lt
);
    import twq_pkg::*;

    t_entry r_ent;
    t_entry n_ent;

    // own entry sorts ahead of the key being inserted
    assign o_lt = r_ent.valid &&
                  ((r_ent.wtime < i_key.wtime) ||
                   ((r_ent.wtime == i_key.wtime) && (r_ent.tid < i_key.tid)));

    always_comb begin
        n_ent = r_ent;
        if (i_ctl.pop) begin
            n_ent = i_next;
        end else if (i_ctl.insert) begin
            if (o_lt) begin
                n_ent = r_ent;
            end else if (i_prev_lt) begin
                n_ent = i_key;
            end else begin
                n_ent = i_prev;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent.valid <= 1'b0;
        end else begin
            r_ent.valid <= n_ent.valid;
        end
        r_ent.wtime <= n_ent.wtime;
        r_ent.tid   <= n_ent.tid;
    end

    assign o_entry = r_ent;

endmodule

FILE: src/timeout_wakeup_queue_unit.sv
// block command: status result registered from S_BLK once the output register is free
// expire command: results come one per cycle while the output register is free
// a sorted row of cells inserts or pops one entry per cycle while the output is free
// next input accepted the cycle after the last result enters the output register
// input taken only when idle
// synchronous active-low reset empties the queue, clears wake times and flags
module timeout_wakeup_queue_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // thread_id, wake_time, period, now_time, zero pad
    input  logic [167:0] i_s_tdata,
    // command
    input  logic         i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // status, woken_thread
    output logic [7:0]   o_m_tdata,
    output logic         o_m_tlast
);
    import twq_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_BLK  = 2'd1;
    localparam logic [1:0] S_POP  = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [RES_W-1:0]  r_n, n_n;
    logic [MAX_THREADS-1:0] r_wait;
    logic [TIME_W-1:0] r_wake [MAX_THREADS];
    t_entry            r_key, n_key;
    logic [STAT_W-1:0] r_status, n_status;
    logic [TIME_W-1:0] r_now, n_now;

    logic              r_m_valid, n_m_valid;
    logic [STAT_W-1:0] r_m_status, n_m_status;
    logic [TID_W-1:0]  r_m_tid, n_m_tid;
    logic              r_m_last, n_m_last;

    logic [TID_W-1:0]  in_tid;
    logic [TIME_W-1:0] in_wake;
    logic [PER_W-1:0]  in_period;
    logic [TIME_W-1:0] in_now;
    logic [THR_W-1:0]  in_idx;
    logic              s_fire;
    logic              out_free;
    logic              head_due;
    logic              next_due;
    logic              set_wait;
    logic              clr_wait;
    logic [THR_W-1:0]  head_idx;
    logic [THR_W-1:0]  key_idx;

    t_cell_ctl         ctl;
    t_entry            ent [MAX_THREADS];
    logic              lt  [MAX_THREADS];
    t_entry            empty_ent;

    assign in_tid    = i_s_tdata[4:0];
    assign in_wake   = i_s_tdata[68:5];
    assign in_period = i_s_tdata[100:69];
    assign in_now    = i_s_tdata[164:101];
    assign in_idx    = THR_W'(in_tid);
    assign head_idx  = THR_W'(ent[0].tid);
    assign key_idx   = THR_W'(r_key.tid);

    assign o_s_tready = (r_state == S_IDLE);
    assign s_fire     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_m_valid || i_m_tready;

    assign empty_ent.valid = 1'b0;
    assign empty_ent.wtime = '0;
    assign empty_ent.tid   = '0;

    assign head_due = ent[0].valid && (ent[0].wtime <= r_now) &&
                      (r_n < RES_W'(MAX_RESULTS));
    assign next_due = ent[1].valid && (ent[1].wtime <= r_now) &&
                      ((r_n + 1'b1) < RES_W'(MAX_RESULTS));

    genvar g;
    generate
        for (g = 0; g < MAX_THREADS; g++) begin : g_cell
            twq_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctl     (ctl),
                .i_key     (r_key),
                .i_prev    ((g == 0) ? empty_ent : ent[(g == 0) ? 0 : g - 1]),
                .i_prev_lt ((g == 0) ? 1'b1 : lt[(g == 0) ? 0 : g - 1]),
                .i_next    ((g == MAX_THREADS - 1) ? empty_ent :
                            ent[(g == MAX_THREADS - 1) ? g : g + 1]),
                .o_entry   (ent[g]),
                .o_lt      (lt[g])
            );
        end
    endgenerate

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_n        = r_n;
        n_key      = r_key;
        n_status   = r_status;
        n_now      = r_now;
        n_m_valid  = i_m_tready ? 1'b0 : r_m_valid;
        n_m_status = r_m_status;
        n_m_tid    = r_m_tid;
        n_m_last   = r_m_last;
        ctl        = '0;
        set_wait   = 1'b0;
        clr_wait   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (s_fire) begin
                    if (i_s_tuser == CMD_BLOCK) begin
                        n_key.valid = 1'b1;
                        n_key.tid   = in_tid;
                        n_key.wtime = (in_wake == '0) ?
                                      (r_wake[in_idx] + TIME_W'(in_period)) : in_wake;
                        if ((32'(in_tid) >= MAX_THREADS) ||
                            (r_count >= CNT_W'(MAX_THREADS))) begin
                            n_status = ST_FULL;
                        end else if (r_wait[in_idx]) begin
                            n_status = ST_WAITING;
                        end else begin
                            n_status = ST_QUEUED;
                        end
                        n_state = S_BLK;
                    end else begin
                        n_now   = in_now;
                        n_n     = '0;
                        n_state = S_POP;
                    end
                end
            end
            S_BLK: begin
                if (out_free) begin
                    n_m_valid  = 1'b1;
                    n_m_status = r_status;
                    n_m_tid    = '0;
                    n_m_last   = 1'b1;
                    if (r_status == ST_QUEUED) begin
                        ctl.insert = 1'b1;
                        set_wait   = 1'b1;
                        n_count    = r_count + 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            S_POP: begin
                if (out_free) begin
                    n_m_valid = 1'b1;
                    if (head_due) begin
                        n_m_status = ST_WOKEN;
                        n_m_tid    = ent[0].tid;
                        n_m_last   = !next_due;
                        ctl.pop    = 1'b1;
                        clr_wait   = 1'b1;
                        if (r_count != '0) begin
                            n_count = r_count - 1'b1;
                        end
                        n_n = r_n + 1'b1;
                        if (!next_due) begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_m_status = ST_NONE;
                        n_m_tid    = '0;
                        n_m_last   = 1'b1;
                        n_state    = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_wait    <= '0;
            r_m_valid <= 1'b0;
            for (int i = 0; i < MAX_THREADS; i++) begin
                r_wake[i] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_m_valid <= n_m_valid;
            if (set_wait) begin
                r_wait[key_idx] <= 1'b1;
                r_wake[key_idx] <= r_key.wtime;
            end
            if (clr_wait) begin
                r_wait[head_idx] <= 1'b0;
            end
        end
        r_n        <= n_n;
        r_key      <= n_key;
        r_status   <= n_status;
        r_now      <= n_now;
        r_m_status <= n_m_status;
        r_m_tid    <= n_m_tid;
        r_m_last   <= n_m_last;
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {r_m_tid, r_m_status};
    assign o_m_tlast  = r_m_last;

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import twq_pkg::*;

    localparam int ITEM_TARGET = 310;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_WAIT  = 40;

    typedef struct {
        logic              cmd;
        logic [TID_W-1:0]  tid;
        logic [TIME_W-1:0] wake;
        logic [PER_W-1:0]  period;
        logic [TIME_W-1:0] now_t;
        bit                sync;
    } t_sleep_req;

    typedef struct {
        logic [STAT_W-1:0] status;
        logic [TID_W-1:0]  thr;
        logic              last;
    } t_wake_res;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    // thread_id, wake_time, period, now_time, zero pad
    logic [167:0] i_s_tdata = '0;
    // command
    logic         i_s_tuser = 1'b0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    // status, woken_thread
    logic [7:0]   o_m_tdata;
    logic         o_m_tlast;

    t_sleep_req        pend_q[$];
    t_wake_res         wake_exp_q[$];
    t_sleep_req        cur;
    logic [TIME_W-1:0] sleep_time[MAX_THREADS];
    bit                asleep[MAX_THREADS];
    int                n_asleep = 0;
    int                n_acc = 0;
    int                n_err = 0;
    int                hold_cnt = 0;
    bit                hold_done = 1'b0;
    int                stall_cnt = 0;
    logic [TIME_W-1:0] base_t;

    timeout_wakeup_queue_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic bit calm();
        return n_acc >= 60 && n_acc < 130;
    endfunction

    // unused fields of each command still carry random values
    function automatic void push_block(logic [TID_W-1:0] tid, logic [TIME_W-1:0] wake,
                                       logic [PER_W-1:0] period, bit sync);
        t_sleep_req r;
        r.cmd    = CMD_BLOCK;
        r.tid    = tid;
        r.wake   = wake;
        r.period = period;
        r.now_t  = rand64();
        r.sync   = sync;
        pend_q.push_back(r);
    endfunction

    function automatic void push_expire(logic [TIME_W-1:0] now_t, bit sync);
        t_sleep_req r;
        r.cmd    = CMD_EXPIRE;
        r.tid    = TID_W'($urandom);
        r.wake   = rand64();
        r.period = $urandom;
        r.now_t  = now_t;
        r.sync   = sync;
        pend_q.push_back(r);
    endfunction

    function automatic logic [TIME_W-1:0] near_time();
        return base_t + 64'($urandom_range(0, 40));
    endfunction

    function automatic void predict_wakeups(t_sleep_req r);
        t_wake_res e;
        int        best;
        int        n;
        e.thr  = '0;
        e.last = 1'b1;
        if (r.cmd == CMD_BLOCK) begin
            if (n_asleep >= MAX_THREADS) begin
                e.status = ST_FULL;
            end else if (asleep[r.tid]) begin
                e.status = ST_WAITING;
            end else begin
                if (r.wake == '0)
                    sleep_time[r.tid] = sleep_time[r.tid] + 64'(r.period);
                else
                    sleep_time[r.tid] = r.wake;
                asleep[r.tid] = 1'b1;
                n_asleep++;
                e.status = ST_QUEUED;
            end
            wake_exp_q.push_back(e);
        end else begin
            n = 0;
            forever begin
                best = -1;
                for (int i = 0; i < MAX_THREADS; i++) begin
                    if (asleep[i] && (best < 0 || sleep_time[i] < sleep_time[best]))
                        best = i;
                end
                if (best < 0 || n >= MAX_RESULTS)
                    break;
                if (sleep_time[best] > r.now_t)
                    break;
                asleep[best] = 1'b0;
                if (n_asleep > 0)
                    n_asleep--;
                e.status = ST_WOKEN;
                e.thr    = best[TID_W-1:0];
                e.last   = 1'b0;
                wake_exp_q.push_back(e);
                n++;
            end
            if (n == 0) begin
                e.status = ST_NONE;
                e.thr    = '0;
                e.last   = 1'b1;
                wake_exp_q.push_back(e);
            end else begin
                wake_exp_q[wake_exp_q.size() - 1].last = 1'b1;
            end
        end
    endfunction

    // every thread sleeps, one more block hits the full queue, then all wake
    function automatic void fill_episode();
        int tids[MAX_THREADS];
        int j;
        int t;
        for (int i = 0; i < MAX_THREADS; i++)
            tids[i] = i;
        for (int i = MAX_THREADS - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = tids[i];
            tids[i] = tids[j];
            tids[j] = t;
        end
        for (int i = 0; i < MAX_THREADS; i++)
            push_block(TID_W'(tids[i]), base_t + 64'($urandom_range(1, 8)), $urandom,
                       i == 0);
        push_block(TID_W'($urandom), near_time() + 64'd1, $urandom, 1'b0);
        push_expire({TIME_W{1'b1}}, 1'b0);
    endfunction

    initial begin
        int  pick;
        bit  filled_a;
        bit  filled_b;
        for (int i = 0; i < MAX_THREADS; i++) begin
            sleep_time[i] = '0;
            asleep[i]     = 1'b0;
        end
        filled_a = 1'b0;
        filled_b = 1'b0;

        push_expire('0, 1'b0);
        push_block(5'd0, {TIME_W{1'b1}}, $urandom, 1'b0);
        push_block(5'd31, 64'd1, $urandom, 1'b0);
        push_block(5'd7, 64'd1, $urandom, 1'b0);
        push_block(5'd5, '0, {PER_W{1'b1}}, 1'b0);
        push_block(5'd0, 64'd5, $urandom, 1'b0);
        push_block(5'd3, '0, '0, 1'b0);
        push_expire('0, 1'b0);
        push_expire('0, 1'b0);
        push_expire({TIME_W{1'b1}}, 1'b0);
        push_block(5'd0, '0, 32'd2, 1'b0);
        push_block(5'd31, '0, '0, 1'b0);
        push_expire(64'd1, 1'b0);
        push_block(5'd12, 64'h8000_0000_0000_0000, $urandom, 1'b0);
        push_expire(64'h7fff_ffff_ffff_ffff, 1'b0);
        push_expire(64'h8000_0000_0000_0000, 1'b1);

        base_t = 64'($urandom_range(1, 1000));
        while (pend_q.size() < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (!filled_a && pend_q.size() >= 110) begin
                filled_a = 1'b1;
                fill_episode();
            end else if (!filled_b && pend_q.size() >= 240) begin
                filled_b = 1'b1;
                base_t = rand64();
                fill_episode();
            end else if (pick < 2) begin
                base_t = rand64();
            end else if (pick < 45) begin
                push_block(TID_W'($urandom), near_time() + 64'd1, $urandom,
                           $urandom_range(0, 99) < 2);
            end else if (pick < 52) begin
                push_block(TID_W'($urandom), '0,
                           $urandom_range(0, 1) ? $urandom : $urandom_range(0, 40), 1'b0);
            end else if (pick < 58) begin
                push_block(TID_W'($urandom), rand64(), $urandom, 1'b0);
            end else if (pick < 64) begin
                push_expire(rand64(), 1'b0);
            end else begin
                push_expire(near_time(), $urandom_range(0, 99) < 3);
                base_t = base_t + 64'($urandom_range(0, 30));
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pend_q.size() != 0 || i_s_tvalid || wake_exp_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (n_err == 0 && wake_exp_q.size() == 0)
            $display("[timeout_wakeup_queue_unit] OK");
        else
            $display("[timeout_wakeup_queue_unit] ERROR");
        $finish;
    end

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                predict_wakeups(cur);
                n_acc <= n_acc + 1;
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (pend_q.size() != 0 && !(pend_q[0].sync && wake_exp_q.size() != 0)
                    && (calm() || $urandom_range(0, 99) >= 15)) begin
                    cur = pend_q.pop_front();
                    i_s_tdata  <= {3'b000, cur.now_t, cur.period, cur.wake, cur.tid};
                    i_s_tuser  <= cur.cmd;
                    i_s_tvalid <= 1'b1;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver, with one long hold-off while items keep coming
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt   <= hold_cnt - 1;
            i_m_tready <= 1'b0;
        end else if (!hold_done && n_acc >= 150) begin
            hold_done  <= 1'b1;
            hold_cnt   <= HOLD_CYCLES;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= calm() || $urandom_range(0, 99) >= 15;
        end
    end

    always @(posedge i_clk) begin : mon
        t_wake_res e;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (wake_exp_q.size() == 0) begin
                if (n_err < 10)
                    $display("unexpected transfer: status %0d thread %0d last %0b",
                             o_m_tdata[2:0], o_m_tdata[7:3], o_m_tlast);
                n_err++;
            end else begin
                e = wake_exp_q.pop_front();
                if (o_m_tdata[2:0] !== e.status || o_m_tdata[7:3] !== e.thr
                    || o_m_tlast !== e.last) begin
                    if (n_err < 10)
                        $display("mismatch: exp status %0d thread %0d last %0b, got %0d %0d %0b",
                                 e.status, e.thr, e.last,
                                 o_m_tdata[2:0], o_m_tdata[7:3], o_m_tlast);
                    n_err++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || !i_rst_n) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_LIMIT) begin
            $display("[timeout_wakeup_queue_unit] ERROR");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

endmodule
